### hw/rtl/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg
// shared types, register codes and the arctangent table builder for the
// setpoint transition ramp
// ----------------------------------------------------------------------------
package spr_pkg;

   localparam int STEP_BITS_DEF  = 24;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int ATAN_DEPTH_DEF = 256;

   localparam int MODE_W       = 2;
   localparam int TOTAL_W      = 24;
   localparam int RANGE_W      = 16;
   localparam int VALUE_W      = 32;
   localparam int DIFF_W       = 33;
   localparam int XF_BITS      = 49;
   localparam int XF_CLAMP_EXP = 48;
   localparam int CORDIC_STEPS = 28;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;

   localparam logic [RANGE_W-1:0] RANGE_RESET = 16'd2560;

   localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ATAN   = 2'd1;

   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   localparam logic [1:0] REG_MODE  = 2'd0;
   localparam logic [1:0] REG_TOTAL = 2'd1;
   localparam logic [1:0] REG_RANGE = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [TOTAL_W-1:0] total_steps;
      logic [RANGE_W-1:0] atan_range;
   } cfg_type;

   // angles scaled so that pi/2 is 2^30
   localparam longint CORDIC_ANGLE [CORDIC_STEPS] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
      64'h00000014, 64'h0000000A, 64'h00000005
   };

   // arithmetic shift that rounds toward zero
   function automatic longint shr_signed(input longint v, input int n);
      if (v >= 0) begin
         return v >>> n;
      end
      return -((-v) >>> n);
   endfunction

   // (2/pi)*atan(k/depth) in q.frac, evaluated at elaboration only
   function automatic logic [31:0] atan_entry(input int k, input int depth, input int frac);
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      x = longint'(depth) <<< 20;
      y = longint'(k) <<< 20;
      z = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = shr_signed(y, i);
         dy = shr_signed(x, i);
         if (y > 0) begin
            x = x + dx;
            y = y - dy;
            z = z + CORDIC_ANGLE[i];
         end else begin
            x = x - dx;
            y = y + dy;
            z = z - CORDIC_ANGLE[i];
         end
      end
      if (z < 0) begin
         z = 0;
      end
      return 32'(z >>> (30 - frac));
   endfunction

endpackage

### hw/rtl/spr_divider.sv
// ----------------------------------------------------------------------------
// spr_divider
// shared restoring divider, one quotient bit per cycle, unsigned operands
// ----------------------------------------------------------------------------
module spr_divider #(
   parameter int NUM_W = 49,
   parameter int DEN_W = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;

   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   trial;
   logic             fits;

   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign fits    = shifted >= {1'b0, den_ff};
   assign trial   = shifted - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### hw/rtl/spr_atan_lut.sv
// ----------------------------------------------------------------------------
// spr_atan_lut
// constant table of (2/pi)*atan(k/depth) with a registered read
// ----------------------------------------------------------------------------
module spr_atan_lut #(
   parameter int ATAN_TABLE_DEPTH = 256,
   parameter int FRAC_BITS        = 16,
   parameter int IDX_W            = $clog2(ATAN_TABLE_DEPTH)
) (
   input  logic                 clock,
   input  logic [IDX_W-1:0]     lut_idx,
   output logic [FRAC_BITS-1:0] lut_data
);

   logic [FRAC_BITS-1:0] rom [ATAN_TABLE_DEPTH];
   logic [FRAC_BITS-1:0] data_ff;

   genvar k;
   for (k = 0; k < ATAN_TABLE_DEPTH; k++) begin : g_rom
      assign rom[k] = FRAC_BITS'(spr_pkg::atan_entry(k, ATAN_TABLE_DEPTH, FRAC_BITS));
   end

   always_ff @(posedge clock) begin
      data_ff <= rom[lut_idx];
   end

   assign lut_data = data_ff;

endmodule

### hw/rtl/spr_csr.sv
// ----------------------------------------------------------------------------
// spr_csr
// configuration registers behind the apb-style port
// ----------------------------------------------------------------------------
module spr_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [spr_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [spr_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [spr_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output spr_pkg::cfg_type               cfg
);

   spr_pkg::cfg_type cfg_ff, cfg_in;
   logic             wr_en;
   logic [1:0]       reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            spr_pkg::REG_MODE:  cfg_in.mode        = pwdata[spr_pkg::MODE_W-1:0];
            spr_pkg::REG_TOTAL: cfg_in.total_steps = pwdata[spr_pkg::TOTAL_W-1:0];
            spr_pkg::REG_RANGE: cfg_in.atan_range  = pwdata[spr_pkg::RANGE_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         spr_pkg::REG_MODE:  prdata = spr_pkg::CSR_DATA_W'(cfg_ff.mode);
         spr_pkg::REG_TOTAL: prdata = spr_pkg::CSR_DATA_W'(cfg_ff.total_steps);
         spr_pkg::REG_RANGE: prdata = spr_pkg::CSR_DATA_W'(cfg_ff.atan_range);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode        <= spr_pkg::MODE_LINEAR;
         cfg_ff.total_steps <= '0;
         cfg_ff.atan_range  <= spr_pkg::RANGE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/setpoint_transition_ramp_core.sv
// ----------------------------------------------------------------------------
// setpoint_transition_ramp_core
// restart or zero-count tick: S_UPDATE registers the result once the response is free
// linear tick: S_QDIV, S_UPDATE; atan tick: S_XSTART to S_WEIGHT, S_QDIV, S_UPDATE,
// using the shared restoring divider (one quotient bit a cycle, NUM_W = 49 by default)
// one item at a time; the next transfer is taken as soon as the result is registered
// synchronous reset clears the output value, step counter and registers (atan_range 2560)
// ----------------------------------------------------------------------------
module setpoint_transition_ramp_core #(
   parameter int STEP_BITS        = spr_pkg::STEP_BITS_DEF,
   parameter int FRAC_BITS        = spr_pkg::FRAC_BITS_DEF,
   parameter int ATAN_TABLE_DEPTH = spr_pkg::ATAN_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [spr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [spr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [spr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [63:0]                    req_tdata,  // desired_value, initial_value
   input  logic [0:0]                     req_tuser,  // operation
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [31:0]                    rsp_tdata   // current_value
);

   localparam int SHIFT    = FRAC_BITS - 8;
   localparam int N1_W     = STEP_BITS + spr_pkg::RANGE_W + SHIFT;
   localparam int N2_W     = 2 * FRAC_BITS + 1;
   localparam int N3_W     = spr_pkg::DIFF_W + FRAC_BITS;
   localparam int N12_W    = (N1_W > N2_W) ? N1_W : N2_W;
   localparam int NUM_W    = (N12_W > N3_W) ? N12_W : N3_W;
   localparam int D1_W     = (STEP_BITS > spr_pkg::TOTAL_W) ? STEP_BITS : spr_pkg::TOTAL_W;
   localparam int DEN_W    = (D1_W > N2_W) ? D1_W : N2_W;
   localparam int MUL_A_W  = (STEP_BITS > FRAC_BITS + 1) ? STEP_BITS : FRAC_BITS + 1;
   localparam int MUL_B_W  = spr_pkg::RANGE_W;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int IDX_W    = $clog2(ATAN_TABLE_DEPTH);
   localparam int SUM_W    = NUM_W + 2;
   localparam int W_W      = FRAC_BITS + 2;
   localparam int XF_BITS  = spr_pkg::XF_BITS;
   localparam int VALUE_W  = spr_pkg::VALUE_W;
   localparam int DIFF_W   = spr_pkg::DIFF_W;

   localparam logic [64:0]          X_LIMIT  = 65'(1) << (32 + SHIFT);
   localparam logic [XF_BITS-1:0]   XF_CLAMP = XF_BITS'(1) << spr_pkg::XF_CLAMP_EXP;
   localparam logic [XF_BITS-1:0]   ONE_X    = XF_BITS'(1) << FRAC_BITS;
   localparam logic [XF_BITS-1:0]   INV_LIM  = XF_BITS'(1) << (2 * FRAC_BITS);
   localparam logic [FRAC_BITS:0]   ONE_F    = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [FRAC_BITS:0]   HALF_F   = ONE_F >> 1;
   localparam logic [PROD_W-1:0]    DEPTH_P  = PROD_W'(ATAN_TABLE_DEPTH);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_XSTART = 10'b0000000010,
      S_XDIV   = 10'b0000000100,
      S_ARG    = 10'b0000001000,
      S_CLASS  = 10'b0000010000,
      S_INVDIV = 10'b0000100000,
      S_IDX    = 10'b0001000000,
      S_WEIGHT = 10'b0010000000,
      S_QDIV   = 10'b0100000000,
      S_UPDATE = 10'b1000000000
   } state_type;

   spr_pkg::cfg_type cfg;

   state_type                   state_ff, state_in;
   logic signed [VALUE_W-1:0]   val_ff, val_in;
   logic [STEP_BITS-1:0]        steps_ff, steps_in;
   logic [STEP_BITS-1:0]        steps_new_ff, steps_new_in;
   logic [VALUE_W-1:0]          new_val_ff, new_val_in;
   logic                        diff_neg_ff, diff_neg_in;
   logic [DIFF_W-1:0]           diff_mag_ff, diff_mag_in;
   logic [XF_BITS-1:0]          xf_ff, xf_in;
   logic                        a_neg_ff, a_neg_in;
   logic [XF_BITS-1:0]          mag_ff, mag_in;
   logic                        small_ff, small_in;
   logic                        half_ff, half_in;
   logic [PROD_W-1:0]           prod_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]          rsp_data_ff, rsp_data_in;

   logic                        mul_en;
   logic [MUL_A_W-1:0]          mul_a;
   logic [MUL_B_W-1:0]          mul_b;

   logic                        div_start;
   logic [NUM_W-1:0]            div_num;
   logic [DEN_W-1:0]            div_den;
   logic                        div_done;
   logic [NUM_W-1:0]            div_quo;

   logic [IDX_W-1:0]            lut_idx;
   logic [FRAC_BITS-1:0]        lut_data;

   logic                        req_op;
   logic signed [VALUE_W-1:0]   req_desired;
   logic [VALUE_W-1:0]          req_initial;
   logic signed [DIFF_W-1:0]    diff_w;
   logic [DIFF_W-1:0]           diff_mag_w;
   logic [XF_BITS-1:0]          half_x;
   logic signed [XF_BITS:0]     a_w;
   logic [PROD_W-1:0]           idx_full;
   logic                        idx_over;
   logic [FRAC_BITS:0]          tab_ext;
   logic [FRAC_BITS:0]          f_w;
   logic [W_W-1:0]              w_raw;
   logic [W_W-1:0]              w_w;
   logic signed [SUM_W-1:0]     quo_s;
   logic signed [SUM_W-1:0]     sum_w;
   logic [VALUE_W-1:0]          sat_w;

   spr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   spr_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   spr_atan_lut #(
      .ATAN_TABLE_DEPTH (ATAN_TABLE_DEPTH),
      .FRAC_BITS        (FRAC_BITS),
      .IDX_W            (IDX_W)
   ) u_atan_lut (
      .clock    (clock),
      .lut_idx  (lut_idx),
      .lut_data (lut_data)
   );

   assign req_op      = req_tuser[0];
   assign req_desired = signed'(req_tdata[31:0]);
   assign req_initial = req_tdata[63:32];

   assign diff_w     = DIFF_W'(req_desired) - DIFF_W'(val_ff);
   assign diff_mag_w = diff_w[DIFF_W-1] ? unsigned'(-diff_w) : unsigned'(diff_w);

   // arctangent argument centered on zero
   assign half_x = (XF_BITS'(cfg.atan_range) << SHIFT) >> 1;
   assign a_w    = signed'({1'b0, xf_ff}) - signed'({1'b0, half_x});

   assign idx_full = prod_ff >> FRAC_BITS;
   assign idx_over = idx_full >= DEPTH_P;

   assign tab_ext = {1'b0, lut_data};
   assign f_w     = small_ff ? (half_ff ? HALF_F : tab_ext) : ONE_F - tab_ext;
   assign w_raw   = a_neg_ff ? {1'b0, ONE_F} - {1'b0, f_w} : {1'b0, ONE_F} + {1'b0, f_w};
   assign w_w     = (w_raw == '0) ? W_W'(1) : w_raw;

   // quotient magnitude carries the sign of the difference, then saturate
   assign quo_s = signed'(SUM_W'(div_quo));
   assign sum_w = SUM_W'(val_ff) + (diff_neg_ff ? -quo_s : quo_s);
   assign sat_w = ((&sum_w[SUM_W-1:VALUE_W-1]) || !(|sum_w[SUM_W-1:VALUE_W-1])) ?
                  sum_w[VALUE_W-1:0] :
                  (sum_w[SUM_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}});

   always_comb begin
      state_in     = state_ff;
      val_in       = val_ff;
      steps_in     = steps_ff;
      steps_new_in = steps_new_ff;
      new_val_in   = new_val_ff;
      diff_neg_in  = diff_neg_ff;
      diff_mag_in  = diff_mag_ff;
      xf_in        = xf_ff;
      a_neg_in     = a_neg_ff;
      mag_in       = mag_ff;
      small_in     = small_ff;
      half_in      = half_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mul_en       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = '0;
      lut_idx      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               diff_neg_in = diff_w[DIFF_W-1];
               diff_mag_in = diff_mag_w;
               mul_en      = 1'b1;
               mul_a       = MUL_A_W'(steps_ff);
               mul_b       = cfg.atan_range;
               priority if (req_op == spr_pkg::OP_RESTART) begin
                  new_val_in   = req_initial;
                  steps_new_in = STEP_BITS'(cfg.total_steps);
                  state_in     = S_UPDATE;
               end else if (steps_ff == '0) begin
                  new_val_in   = unsigned'(req_desired);
                  steps_new_in = steps_ff;
                  state_in     = S_UPDATE;
               end else begin
                  steps_new_in = steps_ff - STEP_BITS'(1);
                  priority if (cfg.mode == spr_pkg::MODE_LINEAR) begin
                     div_start = 1'b1;
                     div_num   = NUM_W'(diff_mag_w);
                     div_den   = DEN_W'(steps_ff);
                     state_in  = S_QDIV;
                  end else if (cfg.mode == spr_pkg::MODE_ATAN) begin
                     state_in = S_XSTART;
                  end else begin
                     new_val_in = unsigned'(val_ff);
                     state_in   = S_UPDATE;
                  end
               end
            end
         end
         S_XSTART: begin
            if (cfg.total_steps == '0) begin
               xf_in    = XF_BITS'(cfg.atan_range) << SHIFT;
               state_in = S_ARG;
            end else begin
               div_start = 1'b1;
               div_num   = NUM_W'(prod_ff) << SHIFT;
               div_den   = DEN_W'(cfg.total_steps);
               state_in  = S_XDIV;
            end
         end
         S_XDIV: begin
            if (div_done) begin
               xf_in    = (65'(div_quo) >= X_LIMIT) ? XF_CLAMP : XF_BITS'(div_quo);
               state_in = S_ARG;
            end
         end
         S_ARG: begin
            a_neg_in = a_w[XF_BITS];
            mag_in   = a_w[XF_BITS] ? XF_BITS'(-a_w) : XF_BITS'(a_w);
            state_in = S_CLASS;
         end
         S_CLASS: begin
            priority if (mag_ff <= ONE_X) begin
               small_in = 1'b1;
               mul_en   = 1'b1;
               mul_a    = MUL_A_W'(mag_ff[FRAC_BITS:0]);
               mul_b    = MUL_B_W'(ATAN_TABLE_DEPTH);
               state_in = S_IDX;
            end else if (mag_ff > INV_LIM) begin
               // reciprocal rounds to zero
               small_in = 1'b0;
               mul_en   = 1'b1;
               state_in = S_IDX;
            end else begin
               small_in  = 1'b0;
               div_start = 1'b1;
               div_num   = NUM_W'(1) << (2 * FRAC_BITS);
               div_den   = DEN_W'(mag_ff);
               state_in  = S_INVDIV;
            end
         end
         S_INVDIV: begin
            if (div_done) begin
               mul_en   = 1'b1;
               mul_a    = MUL_A_W'(div_quo[FRAC_BITS-1:0]);
               mul_b    = MUL_B_W'(ATAN_TABLE_DEPTH);
               state_in = S_IDX;
            end
         end
         S_IDX: begin
            lut_idx  = idx_over ? IDX_W'(ATAN_TABLE_DEPTH - 1) : IDX_W'(idx_full);
            half_in  = small_ff & idx_over;
            state_in = S_WEIGHT;
         end
         S_WEIGHT: begin
            div_start = 1'b1;
            div_num   = NUM_W'(diff_mag_ff) << FRAC_BITS;
            div_den   = DEN_W'(w_w);
            state_in  = S_QDIV;
         end
         S_QDIV: begin
            if (div_done) begin
               new_val_in = sat_w;
               state_in   = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               val_in       = signed'(new_val_ff);
               steps_in     = steps_new_ff;
               rsp_valid_in = 1'b1;
               rsp_data_in  = new_val_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         val_ff       <= '0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         val_ff       <= val_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      steps_new_ff <= steps_new_in;
      new_val_ff   <= new_val_in;
      diff_neg_ff  <= diff_neg_in;
      diff_mag_ff  <= diff_mag_in;
      xf_ff        <= xf_in;
      a_neg_ff     <= a_neg_in;
      mag_ff       <= mag_in;
      small_ff     <= small_in;
      half_ff      <= half_in;
      rsp_data_ff  <= rsp_data_in;
      if (mul_en) begin
         prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
